FILE: sv/grid_frequency_lock_qualifier_assert.svh
// Assertion helpers for the grid frequency lock qualifier
`ifndef GRID_FREQUENCY_LOCK_QUALIFIER_ASSERT_SVH
`define GRID_FREQUENCY_LOCK_QUALIFIER_ASSERT_SVH

`ifndef SYNTHESIS
`define GFLQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gflq assertion failed");
`define GFLQ_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("gflq forbidden condition seen");
`else
`define GFLQ_ASSERT(lbl, clk, rstn, prop)
`define GFLQ_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

FILE: sv/gflq_pkg.sv
`default_nettype none

package gflq_pkg;

  localparam int unsigned AvgLog2  = 5;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned SumW     = TicksW + AvgLog2;
  localparam int unsigned HzW      = 6;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [HzW-1:0] Hz60 = 6'd60;
  localparam logic [HzW-1:0] Hz50 = 6'd50;
  localparam logic [HzW-1:0] HzNone = 6'd0;

  typedef enum logic {
    OP_SAMPLE     = 1'b0,
    OP_RESET_LOCK = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIN60_MAX   = 3'd0,
    CFG_WIN60_MIN   = 3'd1,
    CFG_WIN50_MAX   = 3'd2,
    CFG_WIN50_MIN   = 3'd3,
    CFG_LIMIT_MAX   = 3'd4,
    CFG_LIMIT_MIN   = 3'd5,
    CFG_LOCK_SAMP   = 3'd6,
    CFG_FAULT_CLEAR = 3'd7
  } cfg_idx_e;

  // Highest member first so period_ticks lands in the lowest bits
  typedef struct packed {
    logic              high_freq_fault;
    logic              low_freq_fault;
    logic              grid_low_fault;
    logic              in_start_state;
    logic [TicksW-1:0] alt_period_ticks;
    logic [TicksW-1:0] period_ticks;
  } sample_t;

  // Highest member first so class_hz lands in the lowest bits
  typedef struct packed {
    logic [TicksW-1:0] average_period;
    logic              average_valid;
    logic              clear_high_fault;
    logic              clear_low_fault;
    logic [HzW-1:0]    locked_hz;
    logic              is_locked;
    logic              lock_event;
    logic [HzW-1:0]    class_hz;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/grid_frequency_lock_qualifier.sv
// Grid frequency lock qualifier. Takes one mains-cycle word per clock and
// returns one result word per input word; the input word passes through the
// input register, then the result register. Full rate: a new word is accepted
// every cycle while the result side keeps up; a stalled result holds the
// input register and then the input side. Operation in tuser: 0 takes a
// period sample, 1 clears the lock search. The period used is the secondary
// capture when nonzero, else the primary. Every 32 samples the word carries
// the mean period. Configuration writes take effect at once and are meant to
// be made while no word is in flight.
`default_nettype none

module grid_frequency_lock_qualifier
  import gflq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [TicksW-1:0]    cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // period_ticks, alt_period_ticks, in_start_state, grid_low_fault,
  // low_freq_fault, high_freq_fault, zero fill
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  // op
  input  wire logic                 s_axis_tuser,
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // class_hz, lock_event, is_locked, locked_hz, clear_low_fault,
  // clear_high_fault, average_valid, average_period, zero fill
  output      logic [OutDataW-1:0]  m_axis_tdata
);

  `include "grid_frequency_lock_qualifier_assert.svh"

  localparam int unsigned ResW = $bits(result_t);

  logic [TicksW-1:0] win60_max_q, win60_min_q, win50_max_q, win50_min_q;
  logic [TicksW-1:0] limit_max_q, limit_min_q;
  logic [CountW-1:0] lock_samples_q, fault_clear_q;

  logic              in_valid_q;
  op_e               in_op_q;
  sample_t           in_word_q;
  logic              out_valid_q;
  result_t           out_q;

  logic [CountW-1:0] match_count_q, match_count_d;
  logic [HzW-1:0]    candidate_q, candidate_d;
  logic [HzW-1:0]    lock_hz_q, lock_hz_d;
  logic              lock_flag_q, lock_flag_d;
  logic [CountW-1:0] low_good_q, low_good_d;
  logic [CountW-1:0] high_good_q, high_good_d;
  logic [SumW-1:0]   period_sum_q, period_sum_d;
  logic [AvgLog2-1:0] sample_count_q, sample_count_d;

  logic              advance;
  logic [TicksW-1:0] period;
  logic [SumW-1:0]   sum_next;
  logic [HzW-1:0]    cls;
  logic              in_limit;
  result_t           res_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - ResW){1'b0}}, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win60_max_q    <= '0;
      win60_min_q    <= '0;
      win50_max_q    <= '0;
      win50_min_q    <= '0;
      limit_max_q    <= '0;
      limit_min_q    <= '0;
      lock_samples_q <= 8'd8;
      fault_clear_q  <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIN60_MAX:   win60_max_q    <= cfg_data_i;
        CFG_WIN60_MIN:   win60_min_q    <= cfg_data_i;
        CFG_WIN50_MAX:   win50_max_q    <= cfg_data_i;
        CFG_WIN50_MIN:   win50_min_q    <= cfg_data_i;
        CFG_LIMIT_MAX:   limit_max_q    <= cfg_data_i;
        CFG_LIMIT_MIN:   limit_min_q    <= cfg_data_i;
        CFG_LOCK_SAMP:   lock_samples_q <= cfg_data_i[CountW-1:0];
        CFG_FAULT_CLEAR: fault_clear_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    period   = (in_word_q.alt_period_ticks != '0) ? in_word_q.alt_period_ticks
                                                  : in_word_q.period_ticks;
    sum_next = period_sum_q + SumW'(period);
    in_limit = (period <= limit_max_q) && (period >= limit_min_q);
    if ((period <= win60_max_q) && (period >= win60_min_q)) begin
      cls = Hz60;
    end else if ((period <= win50_max_q) && (period >= win50_min_q)) begin
      cls = Hz50;
    end else begin
      cls = HzNone;
    end

    match_count_d  = match_count_q;
    candidate_d    = candidate_q;
    lock_hz_d      = lock_hz_q;
    lock_flag_d    = lock_flag_q;
    low_good_d     = low_good_q;
    high_good_d    = high_good_q;
    period_sum_d   = period_sum_q;
    sample_count_d = sample_count_q;
    res_d          = '0;

    if (in_op_q == OP_RESET_LOCK) begin
      match_count_d = '0;
      candidate_d   = '0;
      lock_hz_d     = '0;
    end else begin
      sample_count_d = sample_count_q + 1'b1;
      if (sample_count_q == '1) begin
        period_sum_d         = '0;
        res_d.average_valid  = 1'b1;
        res_d.average_period = sum_next[SumW-1:AvgLog2];
      end else begin
        period_sum_d = sum_next;
      end

      if (!in_word_q.grid_low_fault) begin
        res_d.class_hz = cls;
        if (in_word_q.in_start_state) begin
          if (cls == HzNone) begin
            match_count_d = '0;
          end else if (match_count_q == '0) begin
            candidate_d   = cls;
            match_count_d = 8'd1;
          end else if (cls == candidate_q) begin
            if (!lock_flag_q) begin
              match_count_d = match_count_q + 1'b1;
              if (match_count_q >= lock_samples_q) begin
                lock_hz_d        = candidate_q;
                lock_flag_d      = 1'b1;
                res_d.lock_event = 1'b1;
              end
            end
          end else begin
            match_count_d = '0;
          end
        end else if (in_limit) begin
          if (in_word_q.low_freq_fault) begin
            low_good_d = low_good_q + 1'b1;
            if (low_good_q >= fault_clear_q) begin
              low_good_d            = '0;
              res_d.clear_low_fault = 1'b1;
            end
          end
          if (in_word_q.high_freq_fault) begin
            high_good_d = high_good_q + 1'b1;
            if (high_good_q >= fault_clear_q) begin
              high_good_d            = '0;
              res_d.clear_high_fault = 1'b1;
            end
          end
        end
      end
    end
    res_d.is_locked = lock_flag_d;
    res_d.locked_hz = lock_hz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      match_count_q  <= '0;
      candidate_q    <= '0;
      lock_hz_q      <= '0;
      lock_flag_q    <= 1'b0;
      low_good_q     <= '0;
      high_good_q    <= '0;
      period_sum_q   <= '0;
      sample_count_q <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q    <= 1'b1;
        match_count_q  <= match_count_d;
        candidate_q    <= candidate_d;
        lock_hz_q      <= lock_hz_d;
        lock_flag_q    <= lock_flag_d;
        low_good_q     <= low_good_d;
        high_good_q    <= high_good_d;
        period_sum_q   <= period_sum_d;
        sample_count_q <= sample_count_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_word_q <= s_axis_tdata[$bits(sample_t)-1:0];
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  `GFLQ_ASSERT(a_lock_event_has_hz, clk_i, rst_ni,
    (out_valid_q && out_q.lock_event) |-> (out_q.is_locked && out_q.locked_hz != HzNone))
  `GFLQ_ASSERT(a_avg_idle_zero, clk_i, rst_ni,
    (out_valid_q && !out_q.average_valid) |-> (out_q.average_period == '0))
  `GFLQ_ASSERT(a_class_legal, clk_i, rst_ni,
    out_valid_q |-> (out_q.class_hz == HzNone || out_q.class_hz == Hz50 ||
                     out_q.class_hz == Hz60))
  `GFLQ_ASSERT_NEVER(a_lock_sticky, clk_i, rst_ni, $fell(lock_flag_q))
  `GFLQ_ASSERT(a_avg_clears_sum, clk_i, rst_ni,
    (advance && res_d.average_valid) |=> (period_sum_q == '0 && sample_count_q == '0))

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gflq_pkg::*;

  localparam int NumPhases = 10;
  localparam int WordsPerPhase = 123;
  localparam int CycleLimit = 200000;
  localparam int MaxPrinted = 40;

  localparam logic [3:0] ST = 4'b0001;
  localparam logic [3:0] GL = 4'b0010;
  localparam logic [3:0] LF = 4'b0100;
  localparam logic [3:0] HF = 4'b1000;

  // tdata layout of one mains word, lowest field last
  typedef struct packed {
    logic [3:0]        fill;
    logic              high_freq_fault;
    logic              low_freq_fault;
    logic              grid_low_fault;
    logic              in_start_state;
    logic [TicksW-1:0] alt_period_ticks;
    logic [TicksW-1:0] period_ticks;
  } mains_word_t;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [TicksW-1:0] value;
    op_e               op;
    mains_word_t       w;
    int                typed_class;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [TicksW-1:0]   cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  grid_frequency_lock_qualifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  logic [TicksW-1:0]   reg_mirror [8];
  logic [CountW-1:0]   lk_match = '0;
  logic [HzW-1:0]      lk_cand = HzNone;
  logic [HzW-1:0]      lk_value = HzNone;
  logic                lk_flag = 1'b0;
  logic [CountW-1:0]   lo_good = '0;
  logic [CountW-1:0]   hi_good = '0;
  logic [SumW-1:0]     avg_sum = '0;
  logic [AvgLog2:0]    avg_cnt = '0;

  result_t   predicted_results [$];
  plan_row_t plan [$];

  int n_errors = 0;
  int n_words = 0;
  int n_results = 0;
  int n_locks = 0;
  int n_clears = 0;
  int n_means = 0;
  int cycle_count = 0;
  int rx_hold = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  function automatic result_t qualify_word(input op_e op, input mains_word_t w);
    logic [TicksW-1:0] p;
    logic [CountW-1:0] old;
    result_t r;
    r = '0;
    if (op == OP_RESET_LOCK) begin
      lk_match = '0;
      lk_cand = HzNone;
      lk_value = HzNone;
    end else begin
      p = (w.alt_period_ticks != '0) ? w.alt_period_ticks : w.period_ticks;
      avg_sum = avg_sum + p;
      avg_cnt = avg_cnt + 1'b1;
      if (avg_cnt == (1 << AvgLog2)) begin
        r.average_valid = 1'b1;
        r.average_period = avg_sum[AvgLog2 +: TicksW];
        avg_cnt = '0;
        avg_sum = '0;
      end
      if (!w.grid_low_fault) begin
        if (p <= reg_mirror[CFG_WIN60_MAX] && p >= reg_mirror[CFG_WIN60_MIN])
          r.class_hz = Hz60;
        else if (p <= reg_mirror[CFG_WIN50_MAX] && p >= reg_mirror[CFG_WIN50_MIN])
          r.class_hz = Hz50;
        else
          r.class_hz = HzNone;
        if (w.in_start_state) begin
          if (r.class_hz == HzNone) begin
            lk_match = '0;
          end else if (lk_match == '0) begin
            lk_cand = r.class_hz;
            lk_match = 8'd1;
          end else if (r.class_hz == lk_cand) begin
            if (!lk_flag) begin
              old = lk_match;
              lk_match = lk_match + 1'b1;
              if (old >= reg_mirror[CFG_LOCK_SAMP][CountW-1:0]) begin
                lk_value = lk_cand;
                lk_flag = 1'b1;
                r.lock_event = 1'b1;
              end
            end
          end else begin
            lk_match = '0;
          end
        end else if (p <= reg_mirror[CFG_LIMIT_MAX] && p >= reg_mirror[CFG_LIMIT_MIN]) begin
          if (w.low_freq_fault) begin
            old = lo_good;
            lo_good = lo_good + 1'b1;
            if (old >= reg_mirror[CFG_FAULT_CLEAR][CountW-1:0]) begin
              r.clear_low_fault = 1'b1;
              lo_good = '0;
            end
          end
          if (w.high_freq_fault) begin
            old = hi_good;
            hi_good = hi_good + 1'b1;
            if (old >= reg_mirror[CFG_FAULT_CLEAR][CountW-1:0]) begin
              r.clear_high_fault = 1'b1;
              hi_good = '0;
            end
          end
        end
      end
    end
    r.is_locked = lk_flag;
    r.locked_hz = lk_value;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < MaxPrinted)
      $display("mismatch at result %0d: %s got %0h, want %0h", n_results, what, got, want);
    n_errors++;
  endtask

  task automatic check_result(input logic [OutDataW-1:0] data);
    result_t got;
    result_t want;
    got = result_t'(data[$bits(result_t)-1:0]);
    n_results++;
    if (predicted_results.size() == 0) begin
      report_mismatch("word with nothing pending", data, '0);
      return;
    end
    want = predicted_results.pop_front();
    if (got.class_hz !== want.class_hz)
      report_mismatch("class_hz", got.class_hz, want.class_hz);
    if (got.lock_event !== want.lock_event)
      report_mismatch("lock_event", got.lock_event, want.lock_event);
    if (got.is_locked !== want.is_locked)
      report_mismatch("is_locked", got.is_locked, want.is_locked);
    if (got.locked_hz !== want.locked_hz)
      report_mismatch("locked_hz", got.locked_hz, want.locked_hz);
    if (got.clear_low_fault !== want.clear_low_fault)
      report_mismatch("clear_low_fault", got.clear_low_fault, want.clear_low_fault);
    if (got.clear_high_fault !== want.clear_high_fault)
      report_mismatch("clear_high_fault", got.clear_high_fault, want.clear_high_fault);
    if (got.average_valid !== want.average_valid)
      report_mismatch("average_valid", got.average_valid, want.average_valid);
    if (got.average_period !== want.average_period)
      report_mismatch("average_period", got.average_period, want.average_period);
    if (data[OutDataW-1:$bits(result_t)] !== '0)
      report_mismatch("zero fill", data[OutDataW-1:$bits(result_t)], '0);
  endtask

  // result side: check each word, then draw a stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        rx_hold = rx_quiet ? 0 : $urandom_range(3, 0);
      end else if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
      end
      m_axis_tready <= (rx_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("grid_frequency_lock_qualifier regression: fail");
      $finish;
    end
  end

  task automatic send_word(input op_e op, input mains_word_t w, input int typed_class);
    int gap;
    result_t want;
    gap = tx_quiet ? 0 : $urandom_range(3, 0);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = qualify_word(op, w);
    n_words++;
    n_locks += want.lock_event;
    n_clears += want.clear_low_fault + want.clear_high_fault;
    n_means += want.average_valid;
    if (typed_class >= 0) begin
      want = '0;
      want.class_hz = typed_class[HzW-1:0];
    end
    predicted_results.push_back(want);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [TicksW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    reg_mirror[idx] = value;
  endtask

  function automatic void plan_cfg(input cfg_idx_e idx, input logic [TicksW-1:0] value);
    plan_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.value = value;
    row.op = OP_SAMPLE;
    row.w = '0;
    row.typed_class = -1;
    plan.push_back(row);
  endfunction

  function automatic void plan_word(input op_e op, input logic [TicksW-1:0] prim,
                                    input logic [TicksW-1:0] alt, input logic [3:0] flags,
                                    input int typed_class);
    plan_row_t row;
    row.kind = ROW_WORD;
    row.idx = CFG_WIN60_MAX;
    row.value = '0;
    row.op = op;
    row.w = '0;
    row.w.period_ticks = prim;
    row.w.alt_period_ticks = alt;
    row.w.in_start_state = flags[0];
    row.w.grid_low_fault = flags[1];
    row.w.low_freq_fault = flags[2];
    row.w.high_freq_fault = flags[3];
    row.typed_class = typed_class;
    plan.push_back(row);
  endfunction

  task automatic choose_settings(input int ph);
    logic [TicksW-1:0] vals [8];
    int t60;
    int t50;
    int sp;
    if (ph == 0) begin
      vals = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'd255, 16'd255};
    end else if (ph == NumPhases / 2) begin
      vals = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
    end else begin
      t60 = $urandom_range(45000, 300);
      sp = $urandom_range(t60 / 20, 0);
      t50 = t60 + t60 / 5;
      vals[CFG_WIN60_MAX] = t60 + sp;
      vals[CFG_WIN60_MIN] = t60 - sp;
      vals[CFG_WIN50_MAX] = t50 + sp;
      vals[CFG_WIN50_MIN] = t50 - sp;
      vals[CFG_LIMIT_MAX] = t50 + 3 * sp + $urandom_range(50, 0);
      vals[CFG_LIMIT_MIN] = t60 - 3 * sp;
      if ($urandom_range(7, 0) == 0) begin
        vals[CFG_WIN50_MAX] = t50 - sp - 1;
        vals[CFG_WIN50_MIN] = t50 + sp;
      end
      vals[CFG_LOCK_SAMP] = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0)
                                                        : $urandom_range(10, 0);
      vals[CFG_FAULT_CLEAR] = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0)
                                                          : $urandom_range(10, 0);
    end
    for (int i = 0; i < 8; i++) set_reg(cfg_idx_e'(i), vals[i]);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [TicksW-1:0] draw_in(input logic [TicksW-1:0] hi,
                                                input logic [TicksW-1:0] lo);
    if (lo <= hi) return $urandom_range(hi, lo);
    return $urandom;
  endfunction

  task automatic run_random_words(input int count);
    int run_left;
    int run_kind;
    bit run_start;
    bit run_lf;
    bit run_hf;
    logic [TicksW-1:0] p;
    mains_word_t w;
    op_e op;
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        tx_quiet = ($urandom_range(3, 0) == 0);
        rx_quiet = ($urandom_range(3, 0) == 0);
      end
      if (run_left == 0) begin
        run_left = $urandom_range(24, 1);
        run_kind = $urandom_range(7, 0);
        run_start = ($urandom_range(3, 0) != 0);
        run_lf = $urandom_range(1, 0);
        run_hf = $urandom_range(1, 0);
      end
      run_left--;
      case (run_kind)
        0, 1, 2: p = draw_in(reg_mirror[CFG_WIN60_MAX], reg_mirror[CFG_WIN60_MIN]);
        3, 4:    p = draw_in(reg_mirror[CFG_WIN50_MAX], reg_mirror[CFG_WIN50_MIN]);
        5:       p = draw_in(reg_mirror[CFG_LIMIT_MAX], reg_mirror[CFG_LIMIT_MIN]);
        6:       p = reg_mirror[$urandom_range(5, 0)] + $urandom_range(2, 0) - 1;
        default: p = $urandom;
      endcase
      w = '0;
      if (p != '0 && $urandom_range(1, 0)) begin
        w.alt_period_ticks = p;
        w.period_ticks = $urandom;
      end else begin
        w.period_ticks = p;
      end
      if ($urandom_range(15, 0) == 0) begin
        w.period_ticks = $urandom;
        w.alt_period_ticks = $urandom;
      end
      w.in_start_state = run_start;
      w.grid_low_fault = ($urandom_range(15, 0) == 0);
      w.low_freq_fault = run_lf ^ ($urandom_range(7, 0) == 0);
      w.high_freq_fault = run_hf ^ ($urandom_range(7, 0) == 0);
      op = OP_SAMPLE;
      if ($urandom_range(39, 0) == 0) begin
        op = OP_RESET_LOCK;
        w.period_ticks = $urandom;
        w.alt_period_ticks = $urandom;
        w[35:32] = $urandom;
      end
      send_word(op, w, -1);
    end
  endtask

  initial begin
    bit cfg_busy;
    for (int i = 0; i < 8; i++) reg_mirror[i] = '0;
    reg_mirror[CFG_LOCK_SAMP] = 8;
    reg_mirror[CFG_FAULT_CLEAR] = 8;
    cfg_busy = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_WIN60_MAX;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_SAMPLE;

    // reset settings: every window is the single period 0
    plan_word(OP_SAMPLE, 16'h0000, 16'h0000, ST, Hz60);
    plan_word(OP_SAMPLE, 16'hFFFF, 16'h0000, ST, HzNone);
    plan_word(OP_RESET_LOCK, 16'hFFFF, 16'hFFFF, ST | GL | LF | HF, HzNone);
    plan_word(OP_SAMPLE, 16'h0000, 16'h0000, ST | GL | LF | HF, HzNone);
    plan_word(OP_SAMPLE, 16'h0000, 16'h0000, LF | HF, Hz60);
    plan_cfg(CFG_WIN60_MAX, 16'd1000);
    plan_cfg(CFG_WIN60_MIN, 16'd900);
    plan_cfg(CFG_WIN50_MAX, 16'd1250);
    plan_cfg(CFG_WIN50_MIN, 16'd1100);
    plan_cfg(CFG_LIMIT_MAX, 16'd1300);
    plan_cfg(CFG_LIMIT_MIN, 16'd800);
    plan_cfg(CFG_LOCK_SAMP, 16'd1);
    plan_cfg(CFG_FAULT_CLEAR, 16'd0);
    plan_word(OP_SAMPLE, 16'd950, 16'd0, ST, -1);
    plan_word(OP_SAMPLE, 16'd7, 16'd950, ST, -1);
    plan_word(OP_SAMPLE, 16'd1200, 16'd0, ST, -1);
    plan_word(OP_SAMPLE, 16'd1000, 16'd0, LF | HF, -1);
    plan_word(OP_SAMPLE, 16'd1301, 16'd0, LF, -1);
    plan_word(OP_SAMPLE, 16'd800, 16'd0, HF, -1);
    plan_word(OP_RESET_LOCK, 16'd950, 16'd0, ST, -1);
    plan_word(OP_SAMPLE, 16'd899, 16'd0, ST, -1);
    plan_word(OP_SAMPLE, 16'd1100, 16'd0, ST, -1);
    // empty 60 Hz window, full 50 Hz window, top counts
    plan_cfg(CFG_WIN60_MAX, 16'd1000);
    plan_cfg(CFG_WIN60_MIN, 16'd2000);
    plan_cfg(CFG_WIN50_MAX, 16'hFFFF);
    plan_cfg(CFG_WIN50_MIN, 16'h0000);
    plan_cfg(CFG_LIMIT_MAX, 16'hFFFF);
    plan_cfg(CFG_LIMIT_MIN, 16'h0000);
    plan_cfg(CFG_LOCK_SAMP, 16'd255);
    plan_cfg(CFG_FAULT_CLEAR, 16'd255);
    plan_word(OP_SAMPLE, 16'hFFFF, 16'hFFFF, ST, -1);
    plan_word(OP_SAMPLE, 16'd1, 16'd0, LF | HF, -1);
    plan_word(OP_SAMPLE, 16'd5, 16'hFFFF, GL | LF, -1);
    plan_cfg(CFG_WIN60_MIN, 16'h0000);
    plan_cfg(CFG_WIN60_MAX, 16'hFFFF);
    plan_cfg(CFG_LOCK_SAMP, 16'd0);
    plan_cfg(CFG_FAULT_CLEAR, 16'd0);
    plan_word(OP_SAMPLE, 16'h0000, 16'h0000, ST, -1);
    plan_word(OP_SAMPLE, 16'hFFFF, 16'h0000, LF | HF, -1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        if (predicted_results.size() != 0 || s_axis_tvalid) drain();
        set_reg(plan[k].idx, plan[k].value);
        cfg_busy = 1'b1;
      end else begin
        if (cfg_busy) begin
          cfg_we_i <= 1'b0;
          cfg_busy = 1'b0;
        end
        send_word(plan[k].op, plan[k].w, plan[k].typed_class);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      choose_settings(ph);
      run_random_words(WordsPerPhase);
    end
    drain();

    $display("%0d words sent over %0d register settings, %0d results checked",
             n_words, NumPhases + 4, n_results);
    $display("lock events %0d, fault clears %0d, mean periods %0d, mismatches %0d",
             n_locks, n_clears, n_means, n_errors);
    if (n_errors == 0)
      $display("grid_frequency_lock_qualifier regression: pass");
    else
      $display("grid_frequency_lock_qualifier regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/gflq_pkg.sv
sv/grid_frequency_lock_qualifier.sv
tb/tb.sv
